[hdl/i2cbb_pkg.sv]
// i2cbb_pkg: shared types and constants for the two-bus I2C bit-bang master.
// Used by the channel interfaces and by the top level; no dependencies.
package i2cbb_pkg;

   localparam int CMD_W    = 3;
   localparam int BYTE_W   = 8;
   localparam int HALF_W   = 16;
   localparam int TMO_W    = 8;
   localparam int BITCNT_W = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [BYTE_W-1:0]   byte_type;
   typedef logic [HALF_W-1:0]   half_type;
   typedef logic [TMO_W-1:0]    tmo_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // command codes; 6 and 7 act as a plain tick
   localparam cmd_type CMD_TICK  = 3'd0;
   localparam cmd_type CMD_START = 3'd1;
   localparam cmd_type CMD_STOP  = 3'd2;
   localparam cmd_type CMD_SEND  = 3'd3;
   localparam cmd_type CMD_WAIT  = 3'd4;
   localparam cmd_type CMD_READ  = 3'd5;

   localparam csr_idx_type CSR_BUS_SEL = 2'd0;
   localparam csr_idx_type CSR_HALF    = 2'd1;
   localparam csr_idx_type CSR_TMO     = 2'd2;

   localparam logic     BUS_SEL_RST = 1'b0;
   localparam half_type HALF_RST    = 16'd5;
   localparam tmo_type  TMO_RST     = 8'd250;

   typedef enum logic [14:0] {
      PH_IDLE = 15'b000000000000001,
      PH_ST1  = 15'b000000000000010,
      PH_ST2  = 15'b000000000000100,
      PH_SP1  = 15'b000000000001000,
      PH_SP2  = 15'b000000000010000,
      PH_TXD  = 15'b000000000100000,
      PH_TXH  = 15'b000000001000000,
      PH_TXL  = 15'b000000010000000,
      PH_WA1  = 15'b000000100000000,
      PH_WA2  = 15'b000001000000000,
      PH_WAP  = 15'b000010000000000,
      PH_RXL  = 15'b000100000000000,
      PH_RXH  = 15'b001000000000000,
      PH_AK1  = 15'b010000000000000,
      PH_AK2  = 15'b100000000000000
   } phase_type;

endpackage

[hdl/i2cbb_if.sv]
// i2cbb_if: valid/ready channel interfaces for ticks in and pin results out.
// Depends on i2cbb_pkg.
interface i2cbb_req_if;
   import i2cbb_pkg::*;
   logic     valid;
   logic     ready;
   cmd_type  cmd;
   byte_type tx_byte;
   logic     send_ack;
   logic     sda_a_in;
   logic     sda_b_in;

   modport source (output valid, cmd, tx_byte, send_ack, sda_a_in, sda_b_in, input ready);
   modport sink   (input valid, cmd, tx_byte, send_ack, sda_a_in, sda_b_in, output ready);
endinterface

interface i2cbb_rsp_if;
   import i2cbb_pkg::*;
   logic     valid;
   logic     ready;
   logic     scl_a;
   logic     sda_a;
   logic     sda_a_drive;
   logic     scl_b;
   logic     sda_b;
   logic     sda_b_drive;
   logic     busy_res;
   logic     done_res;
   byte_type rx_byte;
   logic     ack_missing;

   modport source (output valid, scl_a, sda_a, sda_a_drive, scl_b, sda_b, sda_b_drive,
                   busy_res, done_res, rx_byte, ack_missing, input ready);
   modport sink   (input valid, scl_a, sda_a, sda_a_drive, scl_b, sda_b, sda_b_drive,
                   busy_res, done_res, rx_byte, ack_missing, output ready);
endinterface

[hdl/i2c_bitbang_master.sv]
// i2c_bitbang_master: two-bus I2C bit-bang byte controller, one tick per transfer.
// Depends on i2cbb_pkg and the channel interfaces in i2cbb_if.sv.
//
//   channel  | dir | carries
//   ---------+-----+----------------------------------------------------
//   req_ch   | in  | one tick: cmd, tx_byte, send_ack, sampled SDA a/b
//   rsp_ch   | out | pin levels/drives of both buses, busy, done, rx, ack
//   csr_*    | in  | bus_select, half_period_ticks, ack_timeout writes
//
// The controller state advances in the cycle a tick is accepted and that tick's
// result lands in the output register.
// A new tick is accepted every cycle unless a result waits unread in that register.
// Synchronous active-high reset: idle, all pins high, both SDA driven.
module i2c_bitbang_master (
   input  logic                   clock,
   input  logic                   reset,
   i2cbb_req_if.sink              req_ch,
   i2cbb_rsp_if.source            rsp_ch,
   input  logic                   csr_we,
   input  i2cbb_pkg::csr_idx_type csr_index,
   input  i2cbb_pkg::csr_data_type csr_wdata
);
   import i2cbb_pkg::*;

   // configuration
   logic     bus_sel_ff;
   half_type half_ff;
   tmo_type  tmo_ff;

   // controller state
   phase_type             phase_ff, phase_in;
   half_type              tick_ff, tick_in;
   logic [BITCNT_W-1:0]   bitcnt_ff, bitcnt_in;
   byte_type              shift_ff, shift_in;
   tmo_type               wait_ff, wait_in;
   logic                  ackc_ff, ackc_in;
   logic [3:0]            pin_ff, pin_in;   // {sda_b, scl_b, sda_a, scl_a}
   logic [1:0]            drv_ff, drv_in;   // {b, a}
   byte_type              lastrx_ff, lastrx_in;
   logic                  ackerr_ff, ackerr_in;
   logic                  done_in;

   // result register
   logic     rsp_valid_ff;
   logic [3:0] rsp_pin_ff;
   logic [1:0] rsp_drv_ff;
   logic     rsp_busy_ff;
   logic     rsp_done_ff;
   byte_type rsp_rx_ff;
   logic     rsp_ackerr_ff;

   logic     accept;
   logic     sda_in;
   half_type half_eff;
   logic [1:0] scl_idx;
   logic [1:0] sda_idx;
   tmo_type  wait_eff;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign sda_in       = bus_sel_ff ? req_ch.sda_b_in : req_ch.sda_a_in;
   assign half_eff     = (half_ff == '0) ? half_type'(1) : half_ff;
   assign scl_idx      = bus_sel_ff ? 2'd2 : 2'd0;
   assign sda_idx      = bus_sel_ff ? 2'd3 : 2'd1;
   // the first poll after SCL rises starts from a cleared count
   assign wait_eff     = (phase_ff == PH_WA2) ? '0 : wait_ff;

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      bitcnt_in = bitcnt_ff;
      shift_in  = shift_ff;
      wait_in   = wait_ff;
      ackc_in   = ackc_ff;
      pin_in    = pin_ff;
      drv_in    = drv_ff;
      lastrx_in = lastrx_ff;
      ackerr_in = ackerr_ff;
      done_in   = 1'b0;

      if (phase_ff == PH_IDLE) begin
         case (req_ch.cmd)
            CMD_START: begin
               drv_in[bus_sel_ff] = 1'b1;
               pin_in[sda_idx]    = 1'b1;
               pin_in[scl_idx]    = 1'b1;
               tick_in  = half_eff;
               phase_in = PH_ST1;
            end
            CMD_STOP: begin
               drv_in[bus_sel_ff] = 1'b1;
               pin_in[sda_idx]    = 1'b0;
               pin_in[scl_idx]    = 1'b1;
               tick_in  = half_eff;
               phase_in = PH_SP1;
            end
            CMD_SEND: begin
               drv_in[bus_sel_ff] = 1'b1;
               pin_in[scl_idx]    = 1'b0;
               pin_in[sda_idx]    = req_ch.tx_byte[BYTE_W-1];
               shift_in  = {req_ch.tx_byte[BYTE_W-2:0], 1'b0};
               bitcnt_in = '0;
               tick_in   = half_eff;
               phase_in  = PH_TXD;
            end
            CMD_WAIT: begin
               pin_in[sda_idx] = 1'b1;
               tick_in  = half_eff;
               phase_in = PH_WA1;
            end
            CMD_READ: begin
               drv_in[bus_sel_ff] = 1'b0;
               pin_in[scl_idx]    = 1'b0;
               shift_in  = '0;
               bitcnt_in = '0;
               ackc_in   = req_ch.send_ack;
               tick_in   = half_eff;
               phase_in  = PH_RXL;
            end
            default: begin
            end
         endcase
      end else if ((phase_ff != PH_WAP) && (tick_ff > half_type'(1))) begin
         tick_in = tick_ff - half_type'(1);
      end else begin
         case (phase_ff)
            PH_ST1: begin
               pin_in[sda_idx] = 1'b0;
               tick_in  = half_eff;
               phase_in = PH_ST2;
            end
            PH_ST2: begin
               pin_in[scl_idx] = 1'b0;
               done_in = 1'b1;
            end
            PH_SP1: begin
               pin_in[sda_idx] = 1'b1;
               tick_in  = half_eff;
               phase_in = PH_SP2;
            end
            PH_SP2: done_in = 1'b1;
            PH_TXD: begin
               pin_in[scl_idx] = 1'b1;
               tick_in  = half_eff;
               phase_in = PH_TXH;
            end
            PH_TXH: begin
               pin_in[scl_idx] = 1'b0;
               tick_in  = half_eff;
               phase_in = PH_TXL;
            end
            PH_TXL: begin
               bitcnt_in = bitcnt_ff + 1'b1;
               if (bitcnt_in[3]) begin
                  done_in = 1'b1;
               end else begin
                  pin_in[sda_idx] = shift_ff[BYTE_W-1];
                  shift_in = {shift_ff[BYTE_W-2:0], 1'b0};
                  tick_in  = half_eff;
                  phase_in = PH_TXD;
               end
            end
            PH_WA1: begin
               drv_in[bus_sel_ff] = 1'b0;
               pin_in[scl_idx]    = 1'b1;
               tick_in  = half_eff;
               phase_in = PH_WA2;
            end
            PH_WA2, PH_WAP: begin
               if (!sda_in) begin
                  pin_in[scl_idx] = 1'b0;
                  ackerr_in = 1'b0;
                  wait_in   = wait_eff;
                  done_in   = 1'b1;
               end else if (wait_eff == tmo_ff) begin
                  // timed out: SCL stays high
                  ackerr_in = 1'b1;
                  wait_in   = wait_eff;
                  done_in   = 1'b1;
               end else begin
                  wait_in  = wait_eff + 1'b1;
                  phase_in = PH_WAP;
               end
            end
            PH_RXL: begin
               pin_in[scl_idx] = 1'b1;
               shift_in = {shift_ff[BYTE_W-2:0], sda_in};
               tick_in  = half_eff;
               phase_in = PH_RXH;
            end
            PH_RXH: begin
               bitcnt_in = bitcnt_ff + 1'b1;
               pin_in[scl_idx] = 1'b0;
               tick_in = half_eff;
               if (bitcnt_in[3]) begin
                  drv_in[bus_sel_ff] = 1'b1;
                  pin_in[sda_idx]    = !ackc_ff;
                  phase_in = PH_AK1;
               end else begin
                  phase_in = PH_RXL;
               end
            end
            PH_AK1: begin
               pin_in[scl_idx] = 1'b1;
               tick_in  = half_eff;
               phase_in = PH_AK2;
            end
            PH_AK2: begin
               pin_in[scl_idx] = 1'b0;
               lastrx_in = shift_ff;
               done_in   = 1'b1;
            end
            default: done_in = 1'b1;
         endcase
      end

      if (done_in) begin
         phase_in = PH_IDLE;
         tick_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_sel_ff <= BUS_SEL_RST;
         half_ff    <= HALF_RST;
         tmo_ff     <= TMO_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BUS_SEL: bus_sel_ff <= csr_wdata[0];
            CSR_HALF:    half_ff    <= csr_wdata[HALF_W-1:0];
            CSR_TMO:     tmo_ff     <= csr_wdata[TMO_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         tick_ff   <= '0;
         bitcnt_ff <= '0;
         shift_ff  <= '0;
         wait_ff   <= '0;
         ackc_ff   <= 1'b0;
         pin_ff    <= 4'hF;
         drv_ff    <= 2'b11;
         lastrx_ff <= '0;
         ackerr_ff <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         bitcnt_ff <= bitcnt_in;
         shift_ff  <= shift_in;
         wait_ff   <= wait_in;
         ackc_ff   <= ackc_in;
         pin_ff    <= pin_in;
         drv_ff    <= drv_in;
         lastrx_ff <= lastrx_in;
         ackerr_ff <= ackerr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_pin_ff    <= pin_in;
         rsp_drv_ff    <= drv_in;
         rsp_busy_ff   <= (phase_in != PH_IDLE);
         rsp_done_ff   <= done_in;
         rsp_rx_ff     <= lastrx_in;
         rsp_ackerr_ff <= ackerr_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.scl_a       = rsp_pin_ff[0];
   assign rsp_ch.sda_a       = rsp_pin_ff[1];
   assign rsp_ch.sda_a_drive = rsp_drv_ff[0];
   assign rsp_ch.scl_b       = rsp_pin_ff[2];
   assign rsp_ch.sda_b       = rsp_pin_ff[3];
   assign rsp_ch.sda_b_drive = rsp_drv_ff[1];
   assign rsp_ch.busy_res    = rsp_busy_ff;
   assign rsp_ch.done_res    = rsp_done_ff;
   assign rsp_ch.rx_byte     = rsp_rx_ff;
   assign rsp_ch.ack_missing = rsp_ackerr_ff;

`ifndef SYNTHESIS
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted tick produced no result");

   a_done_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && done_in) |=> (phase_ff == PH_IDLE))
      else $error("finished command did not return to idle");

   a_idle_tick_clear: assert property (@(posedge clock)
      (phase_ff == PH_IDLE) |-> (tick_ff == '0))
      else $error("delay counter running while idle");

   a_bitcnt_range: assert property (@(posedge clock)
      bitcnt_ff[3] |-> (bitcnt_ff[2:0] == 3'd0))
      else $error("bit counter beyond eight");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> !rsp_busy_ff)
      else $error("result shows done and busy together");
`endif

endmodule

[tb/i2c_bitbang_master_checker.sv]
// i2c_bitbang_master_checker: watches the tick and result channels and the CSR port of
// the two-bus I2C bit-bang master, predicts each result and compares it field by field.
// Depends on i2cbb_pkg and the channel interfaces in hdl/i2cbb_if.sv.
module i2c_bitbang_master_checker (
   input  logic                   clock,
   input  logic                   reset,
   i2cbb_req_if                   req,
   i2cbb_rsp_if                   rsp,
   input  logic                   csr_we,
   input  i2cbb_pkg::csr_idx_type csr_index,
   input  i2cbb_pkg::csr_data_type csr_wdata,
   output int                     taken_count,
   output int                     seen_count,
   output logic                   fsm_idle,
   output int                     fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import i2cbb_pkg::*;

   typedef struct packed {
      logic     scl_a;
      logic     sda_a;
      logic     sda_a_drive;
      logic     scl_b;
      logic     sda_b;
      logic     sda_b_drive;
      logic     busy;
      logic     done;
      byte_type rx;
      logic     ack_missing;
   } bus_levels_type;

   // register copies
   logic     sel;
   half_type half;
   tmo_type  tmo;

   // controller copy
   phase_type   ph;
   half_type    ticks_left;
   logic [3:0]  bits_done;
   byte_type    shreg;
   tmo_type     polls;
   logic        ack_pick;
   logic [3:0]  pins;       // {sda_b, scl_b, sda_a, scl_a}
   logic [1:0]  drv;        // {b, a}
   byte_type    rx_last;
   logic        ack_err;

   bus_levels_type levels_due[$];
   int             fails = 0;

   assign fail_count = fails;

   function automatic void drive_scl(logic v);
      if (sel) pins[2] = v;
      else pins[0] = v;
   endfunction

   function automatic void drive_sda(logic v);
      if (sel) pins[3] = v;
      else pins[1] = v;
   endfunction

   function automatic void own_sda(logic v);
      if (sel) drv[1] = v;
      else drv[0] = v;
   endfunction

   function automatic void arm(phase_type nxt);
      ticks_left = (half == '0) ? half_type'(1) : half;
      ph = nxt;
   endfunction

   function automatic void shift_bit();
      drive_sda(shreg[7]);
      shreg = shreg << 1;
   endfunction

   // one acknowledge sample; 1 when the wait-ack command ends
   function automatic logic poll_ack(logic sda);
      if (!sda) begin
         drive_scl(1'b0);
         ack_err = 1'b0;
         return 1'b1;
      end
      if (polls == tmo) begin
         ack_err = 1'b1;   // SCL stays high here
         return 1'b1;
      end
      polls = polls + 1'b1;
      ph = PH_WAP;
      return 1'b0;
   endfunction

   function automatic void wipe_model();
      sel        = BUS_SEL_RST;
      half       = HALF_RST;
      tmo        = TMO_RST;
      ph         = PH_IDLE;
      ticks_left = '0;
      bits_done  = '0;
      shreg      = '0;
      polls      = '0;
      ack_pick   = 1'b0;
      pins       = 4'hF;
      drv        = 2'b11;
      rx_last    = '0;
      ack_err    = 1'b0;
   endfunction

   task automatic clock_bus_fsm(input cmd_type c, input byte_type b, input logic sack,
                                input logic sda_a_i, input logic sda_b_i,
                                output bus_levels_type r);
      logic sda;
      logic fin;
      sda = sel ? sda_b_i : sda_a_i;
      fin = 1'b0;
      if (ph == PH_IDLE) begin
         case (c)
            CMD_START: begin
               own_sda(1'b1); drive_sda(1'b1); drive_scl(1'b1);
               arm(PH_ST1);
            end
            CMD_STOP: begin
               own_sda(1'b1); drive_sda(1'b0); drive_scl(1'b1);
               arm(PH_SP1);
            end
            CMD_SEND: begin
               own_sda(1'b1); drive_scl(1'b0);
               shreg = b;
               bits_done = '0;
               shift_bit();
               arm(PH_TXD);
            end
            CMD_WAIT: begin
               drive_sda(1'b1);
               arm(PH_WA1);
            end
            CMD_READ: begin
               own_sda(1'b0); drive_scl(1'b0);
               shreg = '0;
               bits_done = '0;
               ack_pick = sack;
               arm(PH_RXL);
            end
            default: ;
         endcase
      end else if (ph == PH_WAP) begin
         fin = poll_ack(sda);
      end else if (ticks_left > 1) begin
         ticks_left = ticks_left - 1'b1;
      end else begin
         case (ph)
            PH_ST1: begin drive_sda(1'b0); arm(PH_ST2); end
            PH_ST2: begin drive_scl(1'b0); fin = 1'b1; end
            PH_SP1: begin drive_sda(1'b1); arm(PH_SP2); end
            PH_SP2: fin = 1'b1;
            PH_TXD: begin drive_scl(1'b1); arm(PH_TXH); end
            PH_TXH: begin drive_scl(1'b0); arm(PH_TXL); end
            PH_TXL: begin
               bits_done = bits_done + 1'b1;
               if (bits_done >= 8) begin
                  fin = 1'b1;
               end else begin
                  shift_bit();
                  arm(PH_TXD);
               end
            end
            PH_WA1: begin own_sda(1'b0); drive_scl(1'b1); arm(PH_WA2); end
            PH_WA2: begin
               polls = '0;
               fin = poll_ack(sda);
            end
            PH_RXL: begin
               drive_scl(1'b1);
               shreg = {shreg[6:0], sda};
               arm(PH_RXH);
            end
            PH_RXH: begin
               bits_done = bits_done + 1'b1;
               drive_scl(1'b0);
               if (bits_done >= 8) begin
                  own_sda(1'b1);
                  drive_sda(!ack_pick);
                  arm(PH_AK1);
               end else begin
                  arm(PH_RXL);
               end
            end
            PH_AK1: begin drive_scl(1'b1); arm(PH_AK2); end
            PH_AK2: begin
               drive_scl(1'b0);
               rx_last = shreg;
               fin = 1'b1;
            end
            default: fin = 1'b1;
         endcase
      end
      if (fin) begin
         ph = PH_IDLE;
         ticks_left = '0;
      end
      r.scl_a       = pins[0];
      r.sda_a       = pins[1];
      r.sda_a_drive = drv[0];
      r.scl_b       = pins[2];
      r.sda_b       = pins[3];
      r.sda_b_drive = drv[1];
      r.busy        = (ph != PH_IDLE);
      r.done        = fin;
      r.rx          = rx_last;
      r.ack_missing = ack_err;
   endtask

   task automatic match_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin : watch
      bus_levels_type want;
      bus_levels_type next_lv;
      if (reset) begin
         wipe_model();
         levels_due.delete();
         taken_count <= 0;
         seen_count  <= 0;
         fsm_idle    <= 1'b1;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BUS_SEL: sel  = csr_wdata[0];
               CSR_HALF:    half = csr_wdata;
               CSR_TMO:     tmo  = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            seen_count <= seen_count + 1;
            if (levels_due.size() == 0) begin
               $error("result transfer with nothing expected");
               fails++;
            end else begin
               want = levels_due.pop_front();
               match_field("scl_a", want.scl_a, rsp.scl_a);
               match_field("sda_a", want.sda_a, rsp.sda_a);
               match_field("sda_a_drive", want.sda_a_drive, rsp.sda_a_drive);
               match_field("scl_b", want.scl_b, rsp.scl_b);
               match_field("sda_b", want.sda_b, rsp.sda_b);
               match_field("sda_b_drive", want.sda_b_drive, rsp.sda_b_drive);
               match_field("busy_res", want.busy, rsp.busy_res);
               match_field("done_res", want.done, rsp.done_res);
               match_field("rx_byte", want.rx, rsp.rx_byte);
               match_field("ack_missing", want.ack_missing, rsp.ack_missing);
            end
         end
         if (req.valid && req.ready) begin
            clock_bus_fsm(req.cmd, req.tx_byte, req.send_ack, req.sda_a_in, req.sda_b_in,
                          next_lv);
            levels_due.push_back(next_lv);
            taken_count <= taken_count + 1;
         end
         fsm_idle <= (ph == PH_IDLE);
      end
   end

endmodule

[tb/i2c_bitbang_master_tb.sv]
// i2c_bitbang_master_tb: drives ticks, commands and CSR writes into the two-bus I2C
// bit-bang master and gives the verdict; checking lives in i2c_bitbang_master_checker.
// Depends on i2cbb_pkg, hdl/i2cbb_if.sv, the block and the checker.
module i2c_bitbang_master_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import i2cbb_pkg::*;

   localparam int unsigned LIMIT = 2_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   csr_idx_type  csr_index;
   csr_data_type csr_wdata;

   int   taken;
   int   seen;
   int   fails;
   logic fsm_idle;

   bit   calm;          // both sides run without gaps
   bit   last_live;     // last transfer carried a real command code
   int   sda_mode;      // 0 random, 1 mostly high, 2 always high
   int   n_items;
   int   n_started;

   i2cbb_req_if req_ch();
   i2cbb_rsp_if rsp_ch();

   i2c_bitbang_master u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   i2c_bitbang_master_checker u_chk (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .taken_count (taken),
      .seen_count  (seen),
      .fsm_idle    (fsm_idle),
      .fail_count  (fails)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic line_level();
      case (sda_mode)
         1:       return ($urandom_range(0, 11) != 0);
         2:       return 1'b1;
         default: return 1'($urandom_range(0, 1));
      endcase
   endfunction

   task automatic hold_valid_off();
      int unsigned n;
      n = calm ? 0 : $urandom_range(0, 10);
      if (n != 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic offer(input cmd_type c, input byte_type b, input logic ack);
      req_ch.valid    <= 1'b1;
      req_ch.cmd      <= c;
      req_ch.tx_byte  <= b;
      req_ch.send_ack <= ack;
      req_ch.sda_a_in <= line_level();
      req_ch.sda_b_in <= line_level();
      do @(posedge clock); while (!req_ch.ready);
      last_live = (c >= CMD_START && c <= CMD_READ);
      n_items++;
   endtask

   // fsm_idle lags one transfer, so a command just placed still counts as busy
   task automatic issue(input cmd_type c, input byte_type b, input logic ack);
      bit placed;
      cmd_type noise;
      placed = 1'b0;
      while (!placed) begin
         hold_valid_off();
         if (fsm_idle && !last_live) begin
            offer(c, b, ack);
            placed = 1'b1;
            n_started++;
         end else begin
            noise = ($urandom_range(0, 3) == 0) ? cmd_type'($urandom_range(0, 7)) : CMD_TICK;
            offer(noise, byte_type'($urandom), 1'($urandom));
         end
      end
   endtask

   task automatic filler(input int n, input bit noisy);
      cmd_type c;
      repeat (n) begin
         hold_valid_off();
         c = (noisy && $urandom_range(0, 3) == 0) ? cmd_type'($urandom_range(0, 7)) : CMD_TICK;
         offer(c, byte_type'($urandom), 1'($urandom));
      end
   endtask

   task automatic settle();
      while (!(fsm_idle && !last_live)) begin
         hold_valid_off();
         offer(CMD_TICK, byte_type'($urandom), 1'($urandom));
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (taken != seen) @(posedge clock);
   endtask

   task automatic set_reg(input csr_idx_type idx, input csr_data_type val);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic run_transaction();
      int pick;
      pick = $urandom_range(0, 19);
      sda_mode = (pick < 12) ? 0 : (pick < 17) ? 1 : 2;
      if ($urandom_range(0, 4) != 0) begin
         issue(CMD_START, byte_type'($urandom), 1'($urandom));
         repeat ($urandom_range(1, 3)) begin
            issue(CMD_SEND, byte_type'($urandom), 1'($urandom));
            issue(CMD_WAIT, byte_type'($urandom), 1'($urandom));
         end
         repeat ($urandom_range(0, 2))
            issue(CMD_READ, byte_type'($urandom), 1'($urandom));
         issue(CMD_STOP, byte_type'($urandom), 1'($urandom));
      end else begin
         // out-of-order commands
         repeat ($urandom_range(1, 4))
            issue(cmd_type'($urandom_range(1, 7)), byte_type'($urandom), 1'($urandom));
      end
      filler($urandom_range(0, 6), 1'b1);
   endtask

   // receiver: random stalls plus one long hold-off that backs up the block
   initial begin : sink_side
      bit held;
      int unsigned n;
      held = 1'b0;
      rsp_ch.ready <= 1'b0;
      wait (!reset);
      forever begin
         if (!held && seen >= 150) begin
            held = 1'b1;
            n = 300;
         end else begin
            n = calm ? 0 : $urandom_range(0, 10);
         end
         if (n != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin : watchdog
      int unsigned cyc;
      cyc = 0;
      while (cyc < LIMIT) begin
         @(posedge clock);
         cyc++;
      end
      $display("timeout after %0d cycles", cyc);
      $display("== FAIL ==");
      $finish;
   end

   initial begin : source_side
      int unsigned pick;
      int phase_end;
      req_ch.valid    <= 1'b0;
      req_ch.cmd      <= CMD_TICK;
      req_ch.tx_byte  <= '0;
      req_ch.send_ack <= 1'b0;
      req_ch.sda_a_in <= 1'b1;
      req_ch.sda_b_in <= 1'b1;
      csr_we    <= 1'b0;
      csr_index <= CSR_BUS_SEL;
      csr_wdata <= '0;
      calm = 1'b0;
      last_live = 1'b0;
      sda_mode = 0;
      n_items = 0;
      n_started = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // every command at reset settings, byte extremes, ignored codes
      issue(CMD_START, 8'h00, 1'b0);
      issue(CMD_SEND, 8'h00, 1'b0);
      issue(CMD_WAIT, 8'h00, 1'b0);
      issue(CMD_SEND, 8'hFF, 1'b1);
      hold_valid_off();
      offer(CMD_START, 8'h55, 1'b0);      // lands while busy
      issue(CMD_WAIT, 8'hFF, 1'b1);
      issue(CMD_READ, 8'h00, 1'b1);
      issue(CMD_READ, 8'hFF, 1'b0);
      issue(CMD_STOP, 8'h00, 1'b0);
      settle();
      offer(cmd_type'(6), 8'hFF, 1'b1);
      offer(cmd_type'(7), 8'h00, 1'b0);

      // acknowledge timeouts at both ends of the count
      set_reg(CSR_TMO, 16'h0000);
      sda_mode = 2;
      issue(CMD_WAIT, 8'h00, 1'b0);
      set_reg(CSR_TMO, 16'hFFFF);
      issue(CMD_WAIT, 8'h00, 1'b0);
      sda_mode = 0;
      issue(CMD_WAIT, 8'h00, 1'b0);

      // zero half period acts as one tick
      set_reg(CSR_HALF, 16'h0000);
      issue(CMD_START, 8'h00, 1'b0);
      issue(CMD_SEND, 8'hA5, 1'b0);
      issue(CMD_STOP, 8'h00, 1'b0);

      // bus switch in the middle of a byte transfer
      set_reg(CSR_HALF, 16'd3);
      issue(CMD_SEND, 8'hA5, 1'b0);
      filler(10, 1'b0);
      set_reg(CSR_BUS_SEL, 16'h0001);
      settle();
      issue(CMD_WAIT, 8'h00, 1'b0);
      issue(CMD_READ, 8'h00, 1'b1);
      filler(20, 1'b0);
      set_reg(CSR_BUS_SEL, 16'hFFFE);
      settle();

      // long half period, no gaps on either side
      calm = 1'b1;
      set_reg(CSR_HALF, 16'd200);
      issue(CMD_STOP, 8'h00, 1'b0);
      settle();
      calm = 1'b0;

      // random phases: fresh register settings, then transactions
      for (int p = 0; p < 8; p++) begin
         calm = ($urandom_range(0, 2) == 0);
         set_reg(CSR_BUS_SEL, csr_data_type'($urandom));
         pick = $urandom_range(0, 7);
         set_reg(CSR_HALF, (pick == 0) ? 16'd0 :
                           (pick < 6)  ? csr_data_type'($urandom_range(1, 3)) :
                                         csr_data_type'($urandom_range(4, 12)));
         pick = $urandom_range(0, 3);
         set_reg(CSR_TMO, {8'($urandom),
                           (pick == 0) ? 8'($urandom_range(0, 3)) :
                           (pick == 1) ? 8'($urandom_range(250, 255)) :
                                         8'($urandom_range(4, 20))});
         phase_end = n_items + 250;
         while (n_items < phase_end) run_transaction();
      end

      drain();
      repeat (8) @(posedge clock);
      $display("%0d ticks transferred, %0d commands placed on both buses;",
               n_items, n_started);
      $display("half period 0..200, ack timeout 0..255, bus switches mid-command");
      if (fails == 0 && taken == seen) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/i2cbb_pkg.sv
hdl/i2cbb_if.sv
hdl/i2c_bitbang_master.sv
tb/i2c_bitbang_master_checker.sv
tb/i2c_bitbang_master_tb.sv
